/* design/graph_coloring_local_max_unit_defines.svh */
// ----------------------------------------------------------------------------
// graph_coloring_local_max_unit assertion macros
// Shared property forms for the checker, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRAPH_COLORING_LOCAL_MAX_UNIT_DEFINES_SVH
`define GRAPH_COLORING_LOCAL_MAX_UNIT_DEFINES_SVH

// same-cycle implication
`define GCLM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gclm check failed");

// next-cycle implication
`define GCLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gclm check failed");

`endif

/* design/gclm_pkg.sv */
// ----------------------------------------------------------------------------
// gclm_pkg
// Shared constants, action codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package gclm_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam int VTX_W    = 6;
    localparam int WEIGHT_W = 20;
    localparam int CNT_W    = 7;
    localparam int ACT_W    = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET_WEIGHT = 2'd0,
        ACT_APPEND     = 2'd1,
        ACT_RUN        = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic weight_wr;
        logic graph_clr;
        logic latch_in;
        logic deg_in_sel;
        logic app_wr;
        logic run_init;
        logic scan_upd;
        logic vc_clr;
        logic vc_inc;
        logic round_inc;
        logic vtx_latch;
        logic nbr_sel;
        logic nb_eval;
        logic commit;
        logic cf_eval;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic app_ok;
        logic v_colored;
        logic deg_zero;
        logic k_last;
        logic vc_last;
        logic round_last;
        logic rounds_zero;
        logic col_zero;
        logic out_taken;
    } status_t;

endpackage

/* design/gclm_ram.sv */
// ----------------------------------------------------------------------------
// gclm_ram
// Generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module gclm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/gclm_ctrl.sv */
// ----------------------------------------------------------------------------
// gclm_ctrl
// Sequencer for loads, degree scan, coloring rounds and result emission
// ----------------------------------------------------------------------------
module gclm_ctrl
    import gclm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ACT_W-1:0] action,
    input  status_t          st,
    output cmd_t             cmd,
    output logic             in_stall
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'b000000000000000001,
        S_APP_RD    = 18'b000000000000000010,
        S_APP_WR    = 18'b000000000000000100,
        S_SCAN_RD   = 18'b000000000000001000,
        S_SCAN_CMP  = 18'b000000000000010000,
        S_VTX_RD    = 18'b000000000000100000,
        S_VTX_CHK   = 18'b000000000001000000,
        S_NB_RD     = 18'b000000000010000000,
        S_NB_DAT    = 18'b000000000100000000,
        S_NB_EVAL   = 18'b000000001000000000,
        S_COMMIT    = 18'b000000010000000000,
        S_EM_RD     = 18'b000000100000000000,
        S_EM_CHK    = 18'b000001000000000000,
        S_EM_NB_RD  = 18'b000010000000000000,
        S_EM_NB_DAT = 18'b000100000000000000,
        S_EM_NB_EV  = 18'b001000000000000000,
        S_EM_LOAD   = 18'b010000000000000000,
        S_EM_WAIT   = 18'b100000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    unique case (action_t'(action))
                        ACT_SET_WEIGHT: cmd.weight_wr = 1'b1;
                        ACT_APPEND:
                        begin
                            if (st.app_ok)
                            begin
                                state_next = S_APP_RD;
                            end
                        end
                        ACT_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = S_SCAN_RD;
                        end
                        ACT_CLEAR: cmd.graph_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_APP_RD:
            begin
                cmd.deg_in_sel = 1'b1;
                state_next     = S_APP_WR;
            end
            S_APP_WR:
            begin
                cmd.app_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_upd = 1'b1;
                if (st.vc_last)
                begin
                    cmd.vc_clr = 1'b1;
                    state_next = st.rounds_zero ? S_EM_RD : S_VTX_RD;
                end
                else
                begin
                    cmd.vc_inc = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_VTX_RD:
            begin
                state_next = S_VTX_CHK;
            end
            S_VTX_CHK, S_COMMIT:
            begin
                if (state_reg == S_VTX_CHK)
                begin
                    cmd.vtx_latch = 1'b1;
                end
                else
                begin
                    cmd.commit = 1'b1;
                end
                if (state_reg == S_VTX_CHK && !st.v_colored)
                begin
                    state_next = st.deg_zero ? S_COMMIT : S_NB_RD;
                end
                else if (st.vc_last)
                begin
                    // end of a round
                    cmd.vc_clr = 1'b1;
                    if (st.round_last)
                    begin
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        cmd.round_inc = 1'b1;
                        state_next    = S_VTX_RD;
                    end
                end
                else
                begin
                    cmd.vc_inc = 1'b1;
                    state_next = S_VTX_RD;
                end
            end
            S_NB_RD:
            begin
                state_next = S_NB_DAT;
            end
            S_NB_DAT:
            begin
                cmd.nbr_sel = 1'b1;
                state_next  = S_NB_EVAL;
            end
            S_NB_EVAL:
            begin
                cmd.nb_eval = 1'b1;
                state_next  = st.k_last ? S_COMMIT : S_NB_RD;
            end
            S_EM_RD:
            begin
                state_next = S_EM_CHK;
            end
            S_EM_CHK:
            begin
                cmd.vtx_latch = 1'b1;
                state_next    = (st.col_zero || st.deg_zero) ? S_EM_LOAD : S_EM_NB_RD;
            end
            S_EM_NB_RD:
            begin
                state_next = S_EM_NB_DAT;
            end
            S_EM_NB_DAT:
            begin
                cmd.nbr_sel = 1'b1;
                state_next  = S_EM_NB_EV;
            end
            S_EM_NB_EV:
            begin
                cmd.cf_eval = 1'b1;
                state_next  = st.k_last ? S_EM_LOAD : S_EM_NB_RD;
            end
            S_EM_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (st.out_taken)
                begin
                    if (st.vc_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.vc_inc = 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* design/gclm_datapath.sv */
// ----------------------------------------------------------------------------
// gclm_datapath
// Graph stores, counters, local-max and color-pick logic, result register
// ----------------------------------------------------------------------------
module gclm_datapath
    import gclm_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
    parameter int CW           = $clog2(DEF_MAX_DEGREE + 2)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             st,
    input  logic                cfg_write,
    input  logic [CNT_W-1:0]    cfg_data,
    input  logic [VTX_W-1:0]    vertex,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [VTX_W-1:0]    neighbor,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [VTX_W-1:0]    vertex_index,
    output logic [CW-1:0]       color,
    output logic                conflict,
    output logic                overflow,
    output logic                last
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int DW   = $clog2(MAX_DEGREE + 1);
    localparam int NAW  = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int UW   = MAX_DEGREE + 2;
    localparam int NLIM = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;

    logic [CNT_W-1:0]    cnt_reg;
    logic [VTX_W-1:0]    in_v_reg;
    logic [VTX_W-1:0]    in_nb_reg;
    logic [CNT_W-1:0]    vc_reg;
    logic [DW-1:0]       k_reg;
    logic [DW-1:0]       round_reg;
    logic [DW-1:0]       rounds_reg;
    logic [VTX_W-1:0]    d_reg;
    logic [CW-1:0]       col_lat_reg;
    logic [DW-1:0]       deg_lat_reg;
    logic [WEIGHT_W-1:0] w_lat_reg;
    logic [UW-1:0]       used_reg;
    logic                lose_reg;
    logic                cf_reg;
    logic                ovf_reg;
    logic [MAX_VERTICES-1:0] w_vld_reg;
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [MAX_VERTICES-1:0] c_vld_reg;
    logic                w_rvld_reg;
    logic                deg_rvld_reg;
    logic                c_rvld_reg;
    logic                out_valid_reg;
    logic [VTX_W-1:0]    out_idx_reg;
    logic [CW-1:0]       out_color_reg;
    logic                out_cf_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [AW-1:0]       v_addr;
    logic [AW-1:0]       in_addr;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       c_raddr;
    logic [AW-1:0]       deg_raddr;
    logic [NAW-1:0]      nb_raddr;
    logic [NAW-1:0]      nb_waddr;
    logic [WEIGHT_W-1:0] w_rdata;
    logic [DW-1:0]       deg_rdata;
    logic [VTX_W-1:0]    nb_rdata;
    logic [CW+DW-1:0]    c_rdata;
    logic [CW+DW-1:0]    c_wdata;
    logic [DW-1:0]       c_tag;
    logic [CW-1:0]       c_val;
    logic [CW-1:0]       c_eff;
    logic                c_vis;
    logic [DW-1:0]       deg_eff;
    logic [WEIGHT_W-1:0] w_eff;
    logic                vertex_ok;
    logic                w_we;
    logic                deg_full;
    logic                app_we;
    logic                c_we;
    logic [CW-1:0]       pick;
    logic                nb_beats;

    function automatic logic [CW-1:0] pick_color(input logic [UW-1:0] used);
        logic [CW-1:0] p;
        p = CW'(MAX_DEGREE + 1);
        for (int c = MAX_DEGREE + 1; c >= 1; c--)
        begin
            if (!used[c])
            begin
                p = CW'(c);
            end
        end
        return p;
    endfunction

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (cnt_reg > CNT_W'(NLIM))
        begin
            n_eff = CNT_W'(NLIM);
        end
        else
        begin
            n_eff = cnt_reg;
        end
    end

    assign vertex_ok = (int'(vertex) < MAX_VERTICES);
    assign v_addr    = AW'(vc_reg);
    assign in_addr   = AW'(in_v_reg);
    assign w_waddr   = AW'(vertex);
    assign w_raddr   = cmd.nbr_sel ? AW'(nb_rdata) : v_addr;
    assign c_raddr   = cmd.nbr_sel ? AW'(nb_rdata) : v_addr;
    assign deg_raddr = cmd.deg_in_sel ? in_addr : v_addr;
    assign deg_eff   = deg_rvld_reg ? deg_rdata : '0;
    assign w_eff     = w_rvld_reg ? w_rdata : '0;
    assign nb_raddr  = NAW'(v_addr) * NAW'(MAX_DEGREE) + NAW'(k_reg);
    assign nb_waddr  = NAW'(in_addr) * NAW'(MAX_DEGREE) + NAW'(deg_eff);
    assign c_tag     = c_rdata[CW+DW-1:CW];
    assign c_val     = c_rdata[CW-1:0];
    assign c_eff     = c_rvld_reg ? c_val : '0;
    // colors written this round stay hidden until the round ends
    assign c_vis     = c_rvld_reg && (c_tag < round_reg);
    assign w_we      = cmd.weight_wr && vertex_ok;
    assign deg_full  = (deg_eff == DW'(MAX_DEGREE));
    assign app_we    = cmd.app_wr && !deg_full;
    assign c_we      = cmd.commit && !lose_reg;
    assign pick      = pick_color(used_reg);
    assign c_wdata   = {round_reg, pick};
    // tie goes to the higher index
    assign nb_beats  = (w_lat_reg < w_eff) ||
                       ((w_lat_reg == w_eff) && (CNT_W'(d_reg) > vc_reg));

    gclm_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_VERTICES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (weight),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    gclm_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree_ram (
        .clk   (clk),
        .we    (app_we),
        .waddr (in_addr),
        .wdata (DW'(deg_eff + 1'b1)),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    gclm_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_nbr_ram (
        .clk   (clk),
        .we    (app_we),
        .waddr (nb_waddr),
        .wdata (in_nb_reg),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    gclm_ram #(.WIDTH(CW + DW), .DEPTH(MAX_VERTICES)) u_color_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (v_addr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CNT_RESET;
            ovf_reg       <= 1'b0;
            w_vld_reg     <= '0;
            deg_vld_reg   <= '0;
            c_vld_reg     <= '0;
            w_rvld_reg    <= 1'b0;
            deg_rvld_reg  <= 1'b0;
            c_rvld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            vc_reg        <= '0;
            k_reg         <= '0;
            round_reg     <= '0;
            rounds_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                cnt_reg <= cfg_data;
            end
            w_rvld_reg   <= w_vld_reg[w_raddr];
            deg_rvld_reg <= deg_vld_reg[deg_raddr];
            c_rvld_reg   <= c_vld_reg[c_raddr];

            if (cmd.graph_clr)
            begin
                ovf_reg     <= 1'b0;
                w_vld_reg   <= '0;
                deg_vld_reg <= '0;
                c_vld_reg   <= '0;
            end
            if (w_we)
            begin
                w_vld_reg[w_waddr] <= 1'b1;
            end
            if (cmd.app_wr)
            begin
                if (deg_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    deg_vld_reg[in_addr] <= 1'b1;
                end
            end
            if (cmd.run_init)
            begin
                c_vld_reg  <= '0;
                vc_reg     <= '0;
                round_reg  <= '0;
                rounds_reg <= '0;
            end
            if (c_we)
            begin
                c_vld_reg[v_addr] <= 1'b1;
            end
            if (cmd.scan_upd && (deg_eff > rounds_reg))
            begin
                rounds_reg <= deg_eff;
            end
            if (cmd.vc_clr)
            begin
                vc_reg <= '0;
            end
            else if (cmd.vc_inc)
            begin
                vc_reg <= CNT_W'(vc_reg + 1'b1);
            end
            if (cmd.round_inc)
            begin
                round_reg <= DW'(round_reg + 1'b1);
            end
            if (cmd.vtx_latch)
            begin
                k_reg <= '0;
            end
            else if (cmd.nb_eval || cmd.cf_eval)
            begin
                k_reg <= DW'(k_reg + 1'b1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_v_reg  <= vertex;
            in_nb_reg <= neighbor;
        end
        if (cmd.nbr_sel)
        begin
            d_reg <= nb_rdata;
        end
        if (cmd.vtx_latch)
        begin
            col_lat_reg <= c_eff;
            deg_lat_reg <= deg_eff;
            w_lat_reg   <= w_eff;
            used_reg    <= '0;
            lose_reg    <= 1'b0;
            cf_reg      <= 1'b0;
        end
        if (cmd.nb_eval)
        begin
            if (c_vis)
            begin
                used_reg[c_val] <= 1'b1;
            end
            else if (nb_beats)
            begin
                lose_reg <= 1'b1;
            end
        end
        if (cmd.cf_eval && (c_eff == col_lat_reg))
        begin
            cf_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_idx_reg   <= vc_reg[VTX_W-1:0];
            out_color_reg <= col_lat_reg;
            out_cf_reg    <= cf_reg;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= st.vc_last;
        end
    end

    assign st.app_ok      = vertex_ok && (int'(neighbor) < MAX_VERTICES);
    assign st.v_colored   = c_vis;
    assign st.deg_zero    = (deg_eff == '0);
    assign st.k_last      = (DW'(k_reg + 1'b1) == deg_lat_reg);
    assign st.vc_last     = (vc_reg == CNT_W'(n_eff - 1'b1));
    assign st.round_last  = (DW'(round_reg + 1'b1) == rounds_reg);
    assign st.rounds_zero = (rounds_reg == '0) && (deg_eff == '0);
    assign st.col_zero    = (c_eff == '0);
    assign st.out_taken   = out_valid_reg && !out_stall;

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign color        = out_color_reg;
    assign conflict     = out_cf_reg;
    assign overflow     = out_ovf_reg;
    assign last         = out_last_reg;

endmodule

/* design/graph_coloring_local_max_unit.sv */
// ----------------------------------------------------------------------------
// graph_coloring_local_max_unit
// Local-maximum graph coloring engine with load, run and clear commands
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one command beat: set weight,
// append neighbor, run, or clear. in_stall is high whenever the sequencer
// is busy; a beat is taken only in the idle state.
// Set weight and clear finish in the idle state; append does a degree
// read-modify-write. Run: a scan over the n vertices finds the largest
// degree, the number of rounds; then per round each uncolored vertex reads
// its listed neighbors and commits, colored vertices are skipped; then per
// vertex a neighbor conflict check (colored only) and the emitted beat,
// plus any receiver stall; the neighbor memory port sets the run time.
// Output channel (out_valid/out_stall) gives one beat per vertex in use,
// vertex_index ascending, last set on the final one. The result register
// holds while out_stall is high and the sequencer waits.
// cfg_write loads vertex_count (reset 64); user: only while idle, unenforced.
// Reset empties the graph: weights, degrees and colors read as zero.
// ----------------------------------------------------------------------------
module graph_coloring_local_max_unit
    import gclm_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [CNT_W-1:0]                    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ACT_W-1:0]                    action,
    input  logic [VTX_W-1:0]                    vertex,
    input  logic [WEIGHT_W-1:0]                 weight,
    input  logic [VTX_W-1:0]                    neighbor,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [VTX_W-1:0]                    vertex_index,
    output logic [$clog2(MAX_DEGREE + 2)-1:0]   color,
    output logic                                conflict,
    output logic                                overflow,
    output logic                                last
);

    cmd_t    cmd;
    status_t st;

    gclm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    gclm_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .CW           ($clog2(MAX_DEGREE + 2))
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .vertex       (vertex),
        .weight       (weight),
        .neighbor     (neighbor),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .vertex_index (vertex_index),
        .color        (color),
        .conflict     (conflict),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

/* design/gclm_checker.sv */
// ----------------------------------------------------------------------------
// gclm_checker
// Port-level checks on the coloring unit, bound to the top level
// ----------------------------------------------------------------------------
`include "graph_coloring_local_max_unit_defines.svh"

module gclm_checker #(
    parameter int COLOR_W = 5
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [5:0]         vertex_index,
    input logic [COLOR_W-1:0] color,
    input logic               conflict,
    input logic               last
);

    // a stalled result beat holds
    `GCLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(vertex_index))

    // commands are taken only once every result beat has gone
    `GCLM_ASSERT_NOW(a_idle_no_out, in_valid && !in_stall, !out_valid)

    // the next vertex needs fresh reads, so beats never come back to back
    `GCLM_ASSERT_NEXT(a_beat_gap, out_valid && !out_stall, !out_valid)

    // an uncolored vertex reports no conflict
    `GCLM_ASSERT_NOW(a_uncolored_clean, out_valid && (color == '0), !conflict)

    // after the final beat the unit is idle again
    `GCLM_ASSERT_NEXT(a_last_idle, out_valid && !out_stall && last, !in_stall)

endmodule

bind graph_coloring_local_max_unit gclm_checker #(
    .COLOR_W ($clog2(MAX_DEGREE + 2))
) u_gclm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .color        (color),
    .conflict     (conflict),
    .last         (last)
);

/* dv/graph_coloring_local_max_unit_tb.sv */
// ----------------------------------------------------------------------------
// graph_coloring_local_max_unit_tb
// Loads random graphs, runs the coloring and checks every emitted color beat
// against a local-maximum coloring predictor, under random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_coloring_local_max_unit_tb;
    import gclm_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int ND = DEF_MAX_DEGREE;

    typedef struct {
        logic [VTX_W-1:0] vertex_index;
        logic [4:0]       color;
        logic             conflict;
        logic             overflow;
        logic             last;
    } color_beat_t;

    typedef struct {
        bit                  is_cfg;
        logic [CNT_W-1:0]    cfg_val;
        action_t             act;
        logic [VTX_W-1:0]    vtx;
        logic [WEIGHT_W-1:0] wt;
        logic [VTX_W-1:0]    nb;
        int                  rep;
        bit                  typed;
        bit                  t_ovf;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [CNT_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [ACT_W-1:0]    action;
    logic [VTX_W-1:0]    vertex;
    logic [WEIGHT_W-1:0] weight;
    logic [VTX_W-1:0]    neighbor;
    logic                out_valid;
    logic                out_stall;
    logic [VTX_W-1:0]    vertex_index;
    logic [4:0]          color;
    logic                conflict;
    logic                overflow;
    logic                last;

    // shadow of the graph held by the block
    logic [WEIGHT_W-1:0] wt_mem [NV];
    int                  deg_mem [NV];
    logic [VTX_W-1:0]    nbr_mem [NV][ND];
    logic [4:0]          cur_col [NV];
    logic [4:0]          nxt_col [NV];
    bit                  ovf_flag;
    int                  vcount;

    color_beat_t color_q[$];
    stim_row_t   dir_q[$];
    int          n_items;
    int          n_errors;
    bit          quiet;
    bit          hold_req;

    graph_coloring_local_max_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .vertex       (vertex),
        .weight       (weight),
        .neighbor     (neighbor),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .color        (color),
        .conflict     (conflict),
        .overflow     (overflow),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #100_000_000;
        $display("[graph_coloring_local_max_unit] ERROR");
        $finish;
    end

    function automatic void clear_graph_model();
        for (int i = 0; i < NV; i++)
        begin
            wt_mem[i]  = '0;
            deg_mem[i] = 0;
            cur_col[i] = '0;
            nxt_col[i] = '0;
        end
        ovf_flag = 1'b0;
    endfunction

    function automatic bool_local_max(int v);
        int d;
        for (int k = 0; k < deg_mem[v]; k++)
        begin
            d = nbr_mem[v][k];
            if (cur_col[d] == 0)
                if (wt_mem[v] < wt_mem[d] || (wt_mem[v] == wt_mem[d] && d > v))
                    return 0;
        end
        return 1;
    endfunction

    function automatic logic [4:0] lowest_free_color(int v);
        bit used [ND + 2];
        logic [4:0] c;
        for (int i = 0; i < ND + 2; i++)
            used[i] = 0;
        for (int k = 0; k < deg_mem[v]; k++)
        begin
            c = cur_col[nbr_mem[v][k]];
            if (c != 0 && c <= ND + 1)
                used[c] = 1;
        end
        for (int i = 1; i <= ND + 1; i++)
            if (!used[i])
                return 5'(i);
        return 5'(ND + 1);
    endfunction

    // updates the shadow graph and queues the color beats a command causes
    function automatic void predict_colors(action_t act, int v, logic [WEIGHT_W-1:0] w,
                                           int nb, bit push_beats);
        int n;
        int rounds;
        color_beat_t b;
        case (act)
            ACT_SET_WEIGHT: wt_mem[v] = w;
            ACT_APPEND:
            begin
                if (deg_mem[v] >= ND)
                    ovf_flag = 1'b1;
                else
                begin
                    nbr_mem[v][deg_mem[v]] = VTX_W'(nb);
                    deg_mem[v]++;
                end
            end
            ACT_CLEAR: clear_graph_model();
            ACT_RUN:
            begin
                n = (vcount < 1) ? 1 : (vcount > NV) ? NV : vcount;
                rounds = 0;
                for (int i = 0; i < NV; i++)
                begin
                    cur_col[i] = '0;
                    nxt_col[i] = '0;
                end
                for (int i = 0; i < n; i++)
                    if (deg_mem[i] > rounds)
                        rounds = deg_mem[i];
                for (int r = 0; r < rounds; r++)
                begin
                    for (int i = 0; i < n; i++)
                        if (cur_col[i] == 0 && bool_local_max(i))
                            nxt_col[i] = lowest_free_color(i);
                    cur_col = nxt_col;
                end
                for (int i = 0; push_beats && i < n; i++)
                begin
                    b.vertex_index = VTX_W'(i);
                    b.color        = cur_col[i];
                    b.conflict     = 1'b0;
                    if (cur_col[i] != 0)
                        for (int k = 0; k < deg_mem[i]; k++)
                            if (cur_col[nbr_mem[i][k]] == cur_col[i])
                                b.conflict = 1'b1;
                    b.overflow = ovf_flag;
                    b.last     = (i == n - 1);
                    color_q.push_back(b);
                end
            end
        endcase
    endfunction

    task automatic send_cmd(action_t act, int v, logic [WEIGHT_W-1:0] w, int nb,
                            bit typed = 0, bit t_ovf = 0);
        int n;
        color_beat_t b;
        in_valid <= 1'b1;
        action   <= act;
        vertex   <= VTX_W'(v);
        weight   <= w;
        neighbor <= VTX_W'(nb);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
        // no idling in the last part of the run
        if (n_items > 280)
            quiet = 1;
        predict_colors(act, v, w, nb, !typed);
        if (typed)
        begin
            // empty graph: every vertex uncolored
            n = (vcount < 1) ? 1 : (vcount > NV) ? NV : vcount;
            for (int i = 0; i < n; i++)
            begin
                b.vertex_index = VTX_W'(i);
                b.color        = '0;
                b.conflict     = 1'b0;
                b.overflow     = t_ovf;
                b.last         = (i == n - 1);
                color_q.push_back(b);
            end
        end
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // config only once all beats are out and a load has had time to finish
    task automatic write_count(logic [CNT_W-1:0] val);
        in_valid <= 1'b0;
        while (color_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        vcount = val;
    endtask

    task automatic add_row(bit is_cfg, int cval, action_t act, int v, int w, int nb,
                           int rep = 1, bit typed = 0, bit t_ovf = 0);
        stim_row_t r;
        r.is_cfg  = is_cfg;
        r.cfg_val = CNT_W'(cval);
        r.act     = act;
        r.vtx     = VTX_W'(v);
        r.wt      = WEIGHT_W'(w);
        r.nb      = VTX_W'(nb);
        r.rep     = rep;
        r.typed   = typed;
        r.t_ovf   = t_ovf;
        dir_q.push_back(r);
    endtask

    // output side stall: random bursts, one long hold-off on request
    initial
    begin
        int  burst;
        int  hold_cnt;
        bit  held;
        out_stall <= 1'b0;
        burst = 0;
        hold_cnt = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (burst > 0)
                burst--;
            else
            begin
                burst = $urandom_range(1, 10);
                out_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        color_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (color_q.size() == 0)
            begin
                $error("color beat with nothing expected: vertex_index %0d", vertex_index);
                n_errors++;
            end
            else
            begin
                e = color_q.pop_front();
                if (vertex_index !== e.vertex_index)
                begin
                    $error("vertex_index expected %0d actual %0d", e.vertex_index, vertex_index);
                    n_errors++;
                end
                if (color !== e.color)
                begin
                    $error("color expected %0d actual %0d", e.color, color);
                    n_errors++;
                end
                if (conflict !== e.conflict)
                begin
                    $error("conflict expected %0d actual %0d", e.conflict, conflict);
                    n_errors++;
                end
                if (overflow !== e.overflow)
                begin
                    $error("overflow expected %0d actual %0d", e.overflow, overflow);
                    n_errors++;
                end
                if (last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, last);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t r;
        int cnt;
        int ne;
        int a;
        int b;
        int wait_cnt;
        bit ties;
        n_items  = 0;
        n_errors = 0;
        quiet    = 0;
        hold_req = 0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= ACT_SET_WEIGHT;
        vertex    <= '0;
        weight    <= '0;
        neighbor  <= '0;
        vcount = CNT_RESET;
        clear_graph_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        add_row(0, 0, ACT_RUN, 0, 0, 0, 1, 1, 0);
        add_row(1, 4, ACT_RUN, 0, 0, 0);
        add_row(0, 0, ACT_SET_WEIGHT, 0, 20'hFFFFF, 0);
        add_row(0, 0, ACT_SET_WEIGHT, 1, 0, 0);
        add_row(0, 0, ACT_SET_WEIGHT, 2, 5, 0);
        add_row(0, 0, ACT_SET_WEIGHT, 3, 5, 0);
        add_row(0, 0, ACT_APPEND, 0, 0, 1);
        add_row(0, 0, ACT_APPEND, 1, 0, 0);
        add_row(0, 0, ACT_APPEND, 2, 0, 3);
        add_row(0, 0, ACT_APPEND, 3, 0, 2);
        add_row(0, 0, ACT_APPEND, 2, 0, 2);
        add_row(0, 0, ACT_APPEND, 0, 0, 63);
        add_row(0, 0, ACT_SET_WEIGHT, 63, 20'hFFFFF, 0);
        add_row(0, 0, ACT_RUN, 0, 0, 0);
        add_row(0, 0, ACT_APPEND, 1, 0, 2, 17);
        add_row(0, 0, ACT_RUN, 0, 0, 0);
        add_row(0, 0, ACT_CLEAR, 0, 0, 0);
        add_row(0, 0, ACT_RUN, 0, 0, 0, 1, 1, 0);
        add_row(1, 0, ACT_RUN, 0, 0, 0, 1, 1, 0);
        add_row(1, 127, ACT_RUN, 0, 0, 0, 1, 1, 0);
        foreach (dir_q[i])
        begin
            r = dir_q[i];
            if (r.is_cfg)
                write_count(r.cfg_val);
            for (int j = 0; j < r.rep; j++)
                send_cmd(r.act, r.vtx, r.wt, r.nb, r.typed, r.t_ovf);
        end

        // random graphs, one per phase
        for (int ph = 0; n_items < 330; ph++)
        begin
            cnt = (ph == 3) ? NV : $urandom_range(2, 12);
            if (ph != 2)
                write_count(CNT_W'(cnt));
            else
                cnt = vcount;
            if (n_items > 280)
                quiet = 1;
            if ($urandom_range(0, 5) != 0)
                send_cmd(ACT_CLEAR, $urandom_range(0, 63), WEIGHT_W'($urandom),
                         $urandom_range(0, 63));
            ties = $urandom_range(0, 1);
            for (int v = 0; v < cnt; v++)
                send_cmd(ACT_SET_WEIGHT, v,
                         ties ? WEIGHT_W'($urandom_range(0, 3)) : WEIGHT_W'($urandom),
                         $urandom_range(0, 63));
            ne = (ph == 3) ? 60 : $urandom_range(0, cnt * 3);
            for (int e = 0; e < ne; e++)
            begin
                a = $urandom_range(0, cnt - 1);
                b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, cnt - 1);
                send_cmd(ACT_APPEND, a, WEIGHT_W'($urandom), b);
                if ($urandom_range(0, 1) == 0 && b < cnt)
                    send_cmd(ACT_APPEND, b, WEIGHT_W'($urandom), a);
            end
            // stray commands of any kind, any index
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    send_cmd(action_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                             WEIGHT_W'($urandom), $urandom_range(0, 63));
            send_cmd(ACT_RUN, $urandom_range(0, 63), WEIGHT_W'($urandom),
                     $urandom_range(0, 63));
            if (ph == 1)
                hold_req = 1;
        end
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (color_q.size() > 0 && wait_cnt < 2_000_000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (color_q.size() > 0)
        begin
            $error("beats still expected at end: %0d", color_q.size());
            n_errors++;
        end
        repeat (50) @(posedge clk);
        if (n_errors == 0)
            $display("[graph_coloring_local_max_unit] OK");
        else
            $display("[graph_coloring_local_max_unit] ERROR");
        $finish;
    end

endmodule

/* graph_coloring_local_max_unit.f */
+incdir+design
design/gclm_pkg.sv
design/gclm_ram.sv
design/gclm_ctrl.sv
design/gclm_datapath.sv
design/graph_coloring_local_max_unit.sv
design/gclm_checker.sv
dv/graph_coloring_local_max_unit_tb.sv
